### hdl/rgb2yuyv_pkg.sv
// Shared types and fixed-point coefficients for the RGB pair to YUYV converter.
`default_nettype none

package rgb2yuyv_pkg;

    localparam int unsigned PIX_W  = 8;
    // signed width of one chroma term and of its offset result
    localparam int unsigned TERM_W = 10;
    // signed width of a weighted chroma sum before the shift
    localparam int unsigned ACC_W  = 18;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0]         luma;
        logic signed [TERM_W-1:0] cb;
        logic signed [TERM_W-1:0] cr;
    } lane_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
    } yuyv_t;

    // luma weights
    localparam logic [15:0] Y_R = 16'd77;
    localparam logic [15:0] Y_G = 16'd150;
    localparam logic [15:0] Y_B = 16'd29;

    // blue-difference weights
    localparam logic signed [ACC_W-1:0] CB_R = -18'sd43;
    localparam logic signed [ACC_W-1:0] CB_G = -18'sd85;
    localparam logic signed [ACC_W-1:0] CB_B = 18'sd128;

    // red-difference weights
    localparam logic signed [ACC_W-1:0] CR_R = 18'sd128;
    localparam logic signed [ACC_W-1:0] CR_G = -18'sd107;
    localparam logic signed [ACC_W-1:0] CR_B = -18'sd21;

    localparam logic signed [TERM_W-1:0] CHROMA_OFS = 10'sd128;
    localparam logic [PIX_W-1:0]         PIX_MAX    = 8'd255;

endpackage

`default_nettype wire

### hdl/rgb2yuyv_lane.sv
// One pixel lane: luma and the two offset chroma terms of a single RGB pixel.
`default_nettype none

module rgb2yuyv_lane (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire rgb2yuyv_pkg::rgb_t     pix,
    output rgb2yuyv_pkg::lane_out_t     res_reg
);
    import rgb2yuyv_pkg::*;

    logic [15:0]              luma_sum;
    logic signed [ACC_W-1:0]  r_s;
    logic signed [ACC_W-1:0]  g_s;
    logic signed [ACC_W-1:0]  b_s;
    logic signed [ACC_W-1:0]  cb_sum;
    logic signed [ACC_W-1:0]  cr_sum;
    lane_out_t                res_next;

    assign r_s = $signed({(ACC_W-PIX_W)'(0), pix.red});
    assign g_s = $signed({(ACC_W-PIX_W)'(0), pix.green});
    assign b_s = $signed({(ACC_W-PIX_W)'(0), pix.blue});

    // weights add to 256, so the luma sum stays within 16 bits
    assign luma_sum = Y_R * 16'(pix.red) + Y_G * 16'(pix.green) + Y_B * 16'(pix.blue);
    assign cb_sum   = CB_R * r_s + CB_G * g_s + CB_B * b_s;
    assign cr_sum   = CR_R * r_s + CR_G * g_s + CR_B * b_s;

    always_comb begin
        res_next.luma = luma_sum[15:8];
        // arithmetic shift gives the floor; the shifted value is within -128..127
        res_next.cb   = TERM_W'(cb_sum >>> 8) + CHROMA_OFS;
        res_next.cr   = TERM_W'(cr_sum >>> 8) + CHROMA_OFS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### hdl/rgb2yuyv_merge.sv
// Merge stage: averages the lanes' chroma terms and saturates both chroma components.
`default_nettype none

module rgb2yuyv_merge (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire rgb2yuyv_pkg::lane_out_t  lane_a,
    input  wire rgb2yuyv_pkg::lane_out_t  lane_b,
    output rgb2yuyv_pkg::yuyv_t           word_reg
);
    import rgb2yuyv_pkg::*;

    logic signed [TERM_W:0]   cb_pair;
    logic signed [TERM_W:0]   cr_pair;
    logic signed [TERM_W-1:0] cb_avg;
    logic signed [TERM_W-1:0] cr_avg;
    yuyv_t                    word_next;

    function automatic logic [PIX_W-1:0] sat8(input logic signed [TERM_W-1:0] v);
        logic [PIX_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({2'b00, PIX_MAX})) begin
            r = PIX_MAX;
        end else begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

    assign cb_pair = (TERM_W+1)'(lane_a.cb) + (TERM_W+1)'(lane_b.cb);
    assign cr_pair = (TERM_W+1)'(lane_a.cr) + (TERM_W+1)'(lane_b.cr);
    assign cb_avg  = TERM_W'(cb_pair >>> 1);
    assign cr_avg  = TERM_W'(cr_pair >>> 1);

    always_comb begin
        word_next.luma_first  = lane_a.luma;
        word_next.chroma_blue = sat8(cb_avg);
        word_next.luma_second = lane_b.luma;
        word_next.chroma_red  = sat8(cr_avg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

### hdl/rgb_pair_to_yuyv_converter.sv
// RGB pixel pair to YUYV 4:2:2 converter: two pixel lanes and a merge stage.
// Pipeline: an input transaction passes the lane register, then the merge register, to output valid.
// Throughput: one pixel pair per cycle while m_tready holds; each stage advances when the stage after it
// is empty or drains in the same cycle, so back-to-back transactions stream through.
// Reset: synchronous active-low aresetn clears the stage valid flags; data registers
// are not reset.
`default_nettype none

module rgb_pair_to_yuyv_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    input  wire logic [47:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // luma_first, chroma_blue, luma_second, chroma_red
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);
    import rgb2yuyv_pkg::*;

    rgb_t      pix_first;
    rgb_t      pix_second;
    lane_out_t lane_first_reg;
    lane_out_t lane_second_reg;
    yuyv_t     word_reg;

    logic stage1_valid_reg, stage1_valid_next;
    logic stage2_valid_reg, stage2_valid_next;
    logic stage1_last_reg;
    logic stage2_last_reg;
    logic load1;
    logic load2;

    assign pix_first.red    = s_tdata[7:0];
    assign pix_first.green  = s_tdata[15:8];
    assign pix_first.blue   = s_tdata[23:16];
    assign pix_second.red   = s_tdata[31:24];
    assign pix_second.green = s_tdata[39:32];
    assign pix_second.blue  = s_tdata[47:40];

    assign load2    = !stage2_valid_reg || m_tready;
    assign load1    = !stage1_valid_reg || load2;
    assign s_tready = load1;

    always_comb begin
        stage1_valid_next = stage1_valid_reg;
        stage2_valid_next = stage2_valid_reg;
        if (load1) begin
            stage1_valid_next = s_tvalid;
        end
        if (load2) begin
            stage2_valid_next = stage1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
        end else begin
            stage1_valid_reg <= stage1_valid_next;
            stage2_valid_reg <= stage2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            stage1_last_reg <= s_tlast;
        end
        if (load2) begin
            stage2_last_reg <= stage1_last_reg;
        end
    end

    rgb2yuyv_lane u_lane_first (
        .aclk    (aclk),
        .en      (load1),
        .pix     (pix_first),
        .res_reg (lane_first_reg)
    );

    rgb2yuyv_lane u_lane_second (
        .aclk    (aclk),
        .en      (load1),
        .pix     (pix_second),
        .res_reg (lane_second_reg)
    );

    rgb2yuyv_merge u_merge (
        .aclk     (aclk),
        .en       (load2),
        .lane_a   (lane_first_reg),
        .lane_b   (lane_second_reg),
        .word_reg (word_reg)
    );

    assign m_tvalid       = stage2_valid_reg;
    assign m_tlast        = stage2_last_reg;
    assign m_tdata[7:0]   = word_reg.luma_first;
    assign m_tdata[15:8]  = word_reg.chroma_blue;
    assign m_tdata[23:16] = word_reg.luma_second;
    assign m_tdata[31:24] = word_reg.chroma_red;

endmodule

`default_nettype wire

### sim/rgb_pair_to_yuyv_converter_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the RGB pixel pair to YUYV converter.
module rgb_pair_to_yuyv_converter_test;
    import rgb2yuyv_pkg::*;

    localparam int RANDOM_PAIRS = 950;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [PIX_W-1:0] red_first;
        logic [PIX_W-1:0] green_first;
        logic [PIX_W-1:0] blue_first;
        logic [PIX_W-1:0] red_second;
        logic [PIX_W-1:0] green_second;
        logic [PIX_W-1:0] blue_second;
        logic             end_of_frame;
        bit               settle_first;   // hold back until the output side is drained
    } pixel_pair_t;

    typedef struct {
        logic [PIX_W-1:0] luma_first;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] luma_second;
        logic [PIX_W-1:0] chroma_red;
        logic             last_of_frame;
    } yuyv_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    logic [47:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    // luma_first, chroma_blue, luma_second, chroma_red
    logic [31:0] m_tdata;
    logic        m_tlast;

    pixel_pair_t pending_pairs[$];
    yuyv_word_t  expected_words[$];
    pixel_pair_t on_bus;

    int pairs_sent    = 0;
    int frames_sent   = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int burst_left    = 8;
    int gap_left      = 0;
    int pattern_age   = 0;
    logic [15:0] stall_pattern = '1;

    rgb_pair_to_yuyv_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int clamp_pix(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic int luma_of(int r, int g, int b);
        return (77 * r + 150 * g + 29 * b) >>> 8;
    endfunction

    // arithmetic shift gives floor for negative weighted sums
    function automatic int blue_diff(int r, int g, int b);
        return ((128 * b - 43 * r - 85 * g) >>> 8) + 128;
    endfunction

    function automatic int red_diff(int r, int g, int b);
        return ((128 * r - 107 * g - 21 * b) >>> 8) + 128;
    endfunction

    function automatic yuyv_word_t convert_pair(pixel_pair_t p);
        yuyv_word_t w;
        int cb;
        int cr;
        cb = (blue_diff(p.red_first, p.green_first, p.blue_first)
              + blue_diff(p.red_second, p.green_second, p.blue_second)) >>> 1;
        cr = (red_diff(p.red_first, p.green_first, p.blue_first)
              + red_diff(p.red_second, p.green_second, p.blue_second)) >>> 1;
        w.luma_first    = PIX_W'(clamp_pix(luma_of(p.red_first, p.green_first,
                                                   p.blue_first)));
        w.chroma_blue   = PIX_W'(clamp_pix(cb));
        w.luma_second   = PIX_W'(clamp_pix(luma_of(p.red_second, p.green_second,
                                                   p.blue_second)));
        w.chroma_red    = PIX_W'(clamp_pix(cr));
        w.last_of_frame = p.end_of_frame;
        return w;
    endfunction

    function automatic pixel_pair_t make_pair(int rf, int gf, int bf,
                                              int rs, int gs, int bs, bit eof);
        pixel_pair_t p;
        p.red_first    = PIX_W'(rf);
        p.green_first  = PIX_W'(gf);
        p.blue_first   = PIX_W'(bf);
        p.red_second   = PIX_W'(rs);
        p.green_second = PIX_W'(gs);
        p.blue_second  = PIX_W'(bs);
        p.end_of_frame = eof;
        p.settle_first = 1'b0;
        return p;
    endfunction

    // biased toward the rails so saturation corners show up often
    function automatic int rand_component();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            2: return $urandom_range(0, 7);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // sender: bursts with random gaps, one pair per transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_words.push_back(convert_pair(on_bus));
                pairs_sent++;
                if (on_bus.end_of_frame)
                    frames_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_pairs.size() == 0 ||
                             (pending_pairs[0].settle_first && expected_words.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = pending_pairs.pop_front();
                    s_tdata <= {on_bus.blue_second, on_bus.green_second, on_bus.red_second,
                                on_bus.blue_first, on_bus.green_first, on_bus.red_first};
                    s_tlast  <= on_bus.end_of_frame;
                    s_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: checks each transaction, stalls on a rotating pattern
    always @(posedge aclk) begin
        yuyv_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                note_failure($sformatf("output with nothing pending: data %h last %b",
                                       m_tdata, m_tlast));
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== want.luma_first || m_tdata[15:8] !== want.chroma_blue ||
                    m_tdata[23:16] !== want.luma_second || m_tdata[31:24] !== want.chroma_red ||
                    m_tlast !== want.last_of_frame)
                    note_failure($sformatf(
                        "word %0d: expected Y0 %h U %h Y1 %h V %h last %b, got %h %h %h %h %b",
                        words_checked, want.luma_first, want.chroma_blue, want.luma_second,
                        want.chroma_red, want.last_of_frame, m_tdata[7:0], m_tdata[15:8],
                        m_tdata[23:16], m_tdata[31:24], m_tlast));
            end
        end
        if (pattern_age == 0) begin
            pattern_age = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
                0: stall_pattern = '1;
                1: stall_pattern = 16'($urandom);
                2: stall_pattern = 16'($urandom | $urandom);
                default: stall_pattern = 16'hFFFF << $urandom_range(1, 12);
            endcase
        end else begin
            pattern_age--;
        end
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        m_tready <= stall_pattern[0];
    end

    initial begin
        pixel_pair_t p;
        int made;
        int pairs_in_frame;

        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(255, 255, 255, 255, 255, 255, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 255, 255, 255, 1));
        pending_pairs.push_back(make_pair(255, 0, 0, 255, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 255, 0, 0, 255, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 255, 0, 0, 255, 0));
        // chroma at both rails
        pending_pairs.push_back(make_pair(255, 255, 0, 255, 255, 0, 0));
        pending_pairs.push_back(make_pair(0, 255, 255, 0, 255, 255, 0));
        pending_pairs.push_back(make_pair(255, 0, 255, 0, 255, 0, 1));
        pending_pairs.push_back(make_pair(255, 0, 0, 0, 0, 255, 0));
        // small negative weighted sums: floor shift must give -1, not 0
        pending_pairs.push_back(make_pair(3, 0, 1, 3, 0, 1, 0));
        pending_pairs.push_back(make_pair(0, 1, 0, 0, 1, 0, 0));
        pending_pairs.push_back(make_pair(3, 0, 1, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 1, 1, 254, 254, 254, 0));
        pending_pairs.push_back(make_pair(170, 85, 170, 85, 170, 85, 0));
        pending_pairs.push_back(make_pair(128, 128, 128, 127, 127, 127, 1));
        pending_pairs.push_back(make_pair(1, 2, 4, 8, 16, 32, 1));

        made = 0;
        while (made < RANDOM_PAIRS) begin
            pairs_in_frame = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 48);
            for (int i = 0; i < pairs_in_frame && made < RANDOM_PAIRS; i++) begin
                p = make_pair(rand_component(), rand_component(), rand_component(),
                              rand_component(), rand_component(), rand_component(),
                              i == pairs_in_frame - 1);
                p.settle_first = (made == 0 || made == RANDOM_PAIRS / 2);
                pending_pairs.push_back(p);
                made++;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_pairs.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d pixel pairs in %0d frames under random bursts and back-pressure,",
                 pairs_sent, frames_sent);
        $display("checked %0d YUYV words, %0d failures.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("rgb_pair_to_yuyv_converter_test OK");
        end else begin
            $display("rgb_pair_to_yuyv_converter_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d words still pending", expected_words.size());
        $display("rgb_pair_to_yuyv_converter_test NOT OK");
        $finish;
    end

endmodule
